// ===== design/vn_pkg.sv =====
// Shared widths and types for the 3D vector normalization pipeline.
`default_nettype none

package vn_pkg;

  localparam int CompW    = 32;            // component width, signed Q16.16
  localparam int SumW     = 2 * CompW;     // sum of squares, always below 2^SumW
  localparam int UnitFrac = 30;            // fraction bits of a unit component
  localparam int QW       = UnitFrac + 1;  // quotient bits, one integer bit
  localparam int UnitW    = 32;            // unit component width, signed Q1.30

  localparam logic [QW-1:0] QSat = {1'b1, {UnitFrac{1'b0}}};

  typedef struct packed {
    logic [2:0][CompW-1:0] a;     // absolute component values
    logic [2:0]            neg;   // component sign
    logic                  zero;  // all components zero
  } side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } dtag_t;

endpackage

`default_nettype wire

// ===== design/vn_in_if.sv =====
// Input channel interface: one vector per transaction.
`default_nettype none

interface vn_in_if import vn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] x_in;
  logic signed [CompW-1:0] y_in;
  logic signed [CompW-1:0] z_in;

  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

`default_nettype wire

// ===== design/vn_out_if.sv =====
// Output channel interface: one normalized vector per transaction.
`default_nettype none

interface vn_out_if import vn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [UnitW-1:0] unit_x;
  logic signed [UnitW-1:0] unit_y;
  logic signed [UnitW-1:0] unit_z;
  logic        [CompW-1:0] magnitude;
  logic                    was_zero;

  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output magnitude, output was_zero, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                  input magnitude, input was_zero, output ready);
endinterface

`default_nettype wire

// ===== design/vn_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module vn_sqrt import vn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SumW-1:0]  sum_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [CompW-1:0] root_o,
  output side_t            side_o
);

  localparam int RemW = CompW + 3;

  logic             vld_q  [CompW];
  logic [RemW-1:0]  rem_q  [CompW];
  logic [CompW-1:0] root_q [CompW];
  logic [SumW-1:0]  rad_q  [CompW];
  side_t            side_q [CompW];

  for (genvar k = 0; k < CompW; k++) begin : g_step
    logic             vld_in;
    logic [RemW-1:0]  rem_in;
    logic [CompW-1:0] root_in;
    logic [SumW-1:0]  rad_in;
    side_t            side_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits and try root bit one
    assign rem_sh = {rem_in[RemW-3:0], rad_in[SumW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[CompW-2:0], ge};
        rad_q[k]  <= {rad_in[SumW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[CompW-1];
  assign root_o  = root_q[CompW-1];
  assign side_o  = side_q[CompW-1];

endmodule

`default_nettype wire

// ===== design/vn_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage.
`default_nettype none

module vn_div import vn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [CompW-1:0]      len_i,
  input  logic [2:0][CompW-1:0] a_i,
  input  dtag_t                 tag_i,
  output logic                  valid_o,
  output logic [2:0][QW-1:0]    quot_o,
  output logic [CompW-1:0]      len_o,
  output dtag_t                 tag_o
);

  logic                  vld_q [QW];
  logic [2:0][CompW-1:0] rem_q [QW];
  logic [2:0][QW-1:0]    quo_q [QW];
  logic [CompW-1:0]      len_q [QW];
  dtag_t                 tag_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                  vld_in;
    logic [2:0][CompW-1:0] rem_in;
    logic [2:0][QW-1:0]    quo_in;
    logic [CompW-1:0]      len_in;
    dtag_t                 tag_in;
    logic [2:0][CompW:0]   rsh;
    logic [2:0][CompW:0]   rdif;
    logic [2:0]            ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = a_i;
      assign quo_in = '0;
      assign len_in = len_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign len_in = len_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      // integer bit first, then one fraction bit per stage
      if (k == 0) begin : g_int
        assign rsh[j] = {1'b0, rem_in[j]};
      end else begin : g_frac
        assign rsh[j] = {rem_in[j], 1'b0};
      end
      assign ge[j]   = rsh[j] >= {1'b0, len_in};
      assign rdif[j] = ge[j] ? rsh[j] - {1'b0, len_in} : rsh[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[k][j] <= rdif[j][CompW-1:0];
          quo_q[k][j] <= {quo_in[j][QW-2:0], ge[j]};
        end
        len_q[k] <= len_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign len_o   = len_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

`default_nettype wire

// ===== design/vector3_normalize_top.sv =====
// Top level of the 3D vector normalization pipeline.
// Stages: 3 front stages, 32 root stages, 31 divider stages and 1 output register.
// Throughput: one vector per cycle; the whole pipeline holds while a result waits.
// Reset: rst_ni clears every valid bit at once; payload registers are not reset.
`default_nettype none

module vector3_normalize_top import vn_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  vn_in_if.sink       in_i,
  vn_out_if.source    out_o
);

  // Advance every stage together whenever the output register is free or drained.
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Stage A: absolute values, signs and the zero test.
  logic [2:0][CompW-1:0] raw;
  logic [2:0][CompW-1:0] abs_d;
  logic [2:0]            neg_d;
  logic                  va_q;
  side_t                 sa_q;

  assign raw[0] = in_i.x_in;
  assign raw[1] = in_i.y_in;
  assign raw[2] = in_i.z_in;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      neg_d[j] = raw[j][CompW-1];
      // the most negative value maps to 2^(CompW-1), still exact unsigned
      abs_d[j] = neg_d[j] ? (~raw[j] + 1'b1) : raw[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q.a    <= abs_d;
      sa_q.neg  <= neg_d;
      sa_q.zero <= (raw == '0);
    end
  end

  // Stage B: three squares, one multiplier per lane.
  logic                 vb_q;
  logic [2:0][SumW-1:0] sq_q;
  side_t                sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq_q[j] <= sa_q.a[j] * sa_q.a[j];
      end
      sb_q <= sa_q;
    end
  end

  // Stage C: sum of squares; it stays below 2^SumW so no carry is lost.
  logic            vc_q;
  logic [SumW-1:0] sum_q;
  side_t           sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
      sc_q  <= sb_q;
    end
  end

  // Square root: truncated length, one bit per stage.
  logic             vs;
  logic [CompW-1:0] root;
  side_t            ss;

  vn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .sum_i   (sum_q),
    .side_i  (sc_q),
    .valid_o (vs),
    .root_o  (root),
    .side_o  (ss)
  );

  // Divide each absolute component by the length into Q1.30.
  dtag_t                 dtag_in;
  logic                  vd;
  logic [2:0][QW-1:0]    quot;
  logic [CompW-1:0]      len;
  dtag_t                 dtag;

  assign dtag_in.neg  = ss.neg;
  assign dtag_in.zero = ss.zero;

  vn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .len_i   (root),
    .a_i     (ss.a),
    .tag_i   (dtag_in),
    .valid_o (vd),
    .quot_o  (quot),
    .len_o   (len),
    .tag_o   (dtag)
  );

  // Output stage: clamp, restore sign, force zeros for a zero vector.
  logic [2:0][UnitW-1:0] unit_d;
  logic [2:0][UnitW-1:0] unit_q;
  logic [CompW-1:0]      mag_q;
  logic                  zero_q;

  always_comb begin
    logic [QW-1:0]    qs;
    logic [UnitW-1:0] qx;
    for (int j = 0; j < 3; j++) begin
      qs = (quot[j] > QSat) ? QSat : quot[j];
      qx = UnitW'(qs);
      if (dtag.zero) begin
        unit_d[j] = '0;
      end else if (dtag.neg[j]) begin
        unit_d[j] = ~qx + 1'b1;
      end else begin
        unit_d[j] = qx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= unit_d;
      mag_q  <= dtag.zero ? '0 : len;
      zero_q <= dtag.zero;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.unit_x    = unit_q[0];
  assign out_o.unit_y    = unit_q[1];
  assign out_o.unit_z    = unit_q[2];
  assign out_o.magnitude = mag_q;
  assign out_o.was_zero  = zero_q;

`ifndef SYNTHESIS
  localparam logic signed [UnitW-1:0] UnitMax = UnitW'(QSat);
  localparam logic signed [UnitW-1:0] UnitMin = -UnitMax;

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && zero_q |-> mag_q == '0 && unit_q == '0)
    else $error("zero vector gave nonzero result");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !zero_q |-> mag_q != '0)
    else $error("nonzero vector gave zero length");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $signed(unit_q[0]) <= UnitMax && $signed(unit_q[0]) >= UnitMin
               && $signed(unit_q[1]) <= UnitMax && $signed(unit_q[1]) >= UnitMin
               && $signed(unit_q[2]) <= UnitMax && $signed(unit_q[2]) >= UnitMin)
    else $error("unit component out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(unit_q) && $stable(mag_q) && out_vld_q)
    else $error("result changed during stall");
`endif

endmodule

`default_nettype wire
